// ===== hw/rtl/ptsbc_pkg.sv =====
// Package for the point-to-beam-axis projection pipeline.
// Holds register indexes, stage numbering, shared types and helper functions.
// No dependencies.
`default_nettype none

package ptsbc_pkg;

   // Configuration port geometry
   localparam int CSR_DATA_W = 16;
   localparam int CSR_IDX_W  = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TOP_X,
      CSR_TOP_Y,
      CSR_BOTTOM_X,
      CSR_BOTTOM_Y,
      CSR_BEAM_WIDTH,
      CSR_BEAM_LENGTH
   } csr_index_type;

   // Iteration counts of the step units
   localparam int SQ_BITS = 32;   // root bits of isqrt(L2 * 2^28)
   localparam int FD_BITS = 18;   // quotient bits of the foot offset
   localparam int QD_BITS = 16;   // quotient bits of across / along

   // Stage numbering (register stage that holds the value)
   localparam int ST_PRE      = 4;
   localparam int ST_SQ_END   = ST_PRE + SQ_BITS;
   localparam int ST_DEN      = ST_SQ_END + 1;
   localparam int ST_OVF      = ST_DEN + 1;
   localparam int ST_DIV_END  = ST_OVF + QD_BITS;
   localparam int ST_OUT      = ST_DIV_END + 1;
   localparam int ST_FNUM     = ST_PRE + 1;
   localparam int ST_FDIV_END = ST_FNUM + FD_BITS;
   localparam int ST_FOOT     = ST_FDIV_END + 1;

   // Saturation limits
   localparam logic signed [15:0] ACROSS_MAX = 16'sh7FFF;
   localparam logic signed [15:0] ACROSS_MIN = 16'sh8000;
   localparam logic [15:0]        ALONG_MAX  = 16'hFFFF;
   localparam logic [15:0]        ALONG_SAT_NEG = 16'd32768;
   localparam logic [15:0]        ALONG_SAT_POS = 16'd32767;

   typedef struct packed {
      logic neg;      // cross product below zero
      logic l2zero;   // zero-length axis
   } meta_type;

   typedef struct packed {
      logic signed [15:0] fx;
      logic signed [15:0] fy;
      logic               sat;
   } foot_type;

   // Trial subtrahend of one digit step of the square root
   function automatic logic [64:0] sqrt_trial(input logic [31:0] root, input int unsigned k);
      return ({33'd0, root} << (k + 1)) + (65'd1 << (2 * k));
   endfunction

   // Clamp a foot coordinate to 16 bits; bit 16 flags a clamp
   function automatic logic [16:0] clamp_foot(input logic signed [19:0] v);
      logic [16:0] r;
      if (v > 20'sd32767)
         r = {1'b1, 16'h7FFF};
      else if (v < -20'sd32768)
         r = {1'b1, 16'h8000};
      else
         r = {1'b0, v[15:0]};
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/point_to_segment_beam_coords.sv =====
// Top level of the point-to-beam-axis projection pipeline.
// Uses ptsbc_pkg for stage numbering, register indexes, types and helpers.
`default_nettype none

// Projects each centroid onto the beam axis from the bottom to the top
// endpoint and returns the perpendicular foot, the across-beam position
// (Q2.13, signed) and the along-beam position (Q2.14). busy stays low: a
// new point is taken in every cycle, and each one comes back as a single
// rsp_valid beat, in order. The pipeline depth is set by the 32-stage
// digit-by-digit square root of L2 * 2^28, followed by a multiply stage,
// an overflow check and a 16-stage restoring divider; the foot divider
// runs alongside and is delayed to match. There is no back-pressure: take
// every rsp_valid beat when it shows. Write the csr_ registers only while
// no point is in flight.
module point_to_segment_beam_coords (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  start,
   output logic                                       busy,
   input  wire logic [15:0]                           req_point_x,
   input  wire logic [15:0]                           req_point_y,
   output logic                                       rsp_valid,
   output logic signed [15:0]                         rsp_across_pos,
   output logic [15:0]                                rsp_along_pos,
   output logic signed [15:0]                         rsp_foot_x,
   output logic signed [15:0]                         rsp_foot_y,
   output logic                                       rsp_saturated,
   input  wire logic                                  csr_we,
   input  wire logic [ptsbc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [ptsbc_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int SqBits    = ptsbc_pkg::SQ_BITS;
   localparam int FdBits    = ptsbc_pkg::FD_BITS;
   localparam int QdBits    = ptsbc_pkg::QD_BITS;
   localparam int StPre     = ptsbc_pkg::ST_PRE;
   localparam int StSqEnd   = ptsbc_pkg::ST_SQ_END;
   localparam int StOvf     = ptsbc_pkg::ST_OVF;
   localparam int StDivEnd  = ptsbc_pkg::ST_DIV_END;
   localparam int StOut     = ptsbc_pkg::ST_OUT;
   localparam int StFnum    = ptsbc_pkg::ST_FNUM;
   localparam int StFdivEnd = ptsbc_pkg::ST_FDIV_END;
   localparam int StFoot    = ptsbc_pkg::ST_FOOT;

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic signed [15:0] top_x_ff, top_y_ff, bottom_x_ff, bottom_y_ff;
   logic [15:0]        beam_width_ff, beam_length_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         top_x_ff       <= '0;
         top_y_ff       <= '0;
         bottom_x_ff    <= '0;
         bottom_y_ff    <= '0;
         beam_width_ff  <= '0;
         beam_length_ff <= '0;
      end else if (csr_we) begin
         case (ptsbc_pkg::csr_index_type'(csr_index))
            ptsbc_pkg::CSR_TOP_X:       top_x_ff       <= csr_wdata;
            ptsbc_pkg::CSR_TOP_Y:       top_y_ff       <= csr_wdata;
            ptsbc_pkg::CSR_BOTTOM_X:    bottom_x_ff    <= csr_wdata;
            ptsbc_pkg::CSR_BOTTOM_Y:    bottom_y_ff    <= csr_wdata;
            ptsbc_pkg::CSR_BEAM_WIDTH:  beam_width_ff  <= csr_wdata;
            ptsbc_pkg::CSR_BEAM_LENGTH: beam_length_ff <= csr_wdata;
            default: ;   // drop writes to unused indexes
         endcase
      end
   end

   // Axis a=top-bottom; user keeps config static while points in flight, unenforced
   logic signed [16:0] ax, ay;
   assign ax = $signed({top_x_ff[15], top_x_ff}) - $signed({bottom_x_ff[15], bottom_x_ff});
   assign ay = $signed({top_y_ff[15], top_y_ff}) - $signed({bottom_y_ff[15], bottom_y_ff});

   // Every start beat is taken: the pipeline never stalls
   assign busy = 1'b0;

   // Valid bits travel one stage per cycle alongside the data
   logic [StOut:1] vld_ff;

   always_ff @(posedge clock) begin
      if (reset)
         vld_ff <= '0;
      else
         vld_ff <= {vld_ff[StOut-1:1], start};
   end

   // ------------------------------------------------------------------
   // Stage 1: point relative to bottom, b = point - bottom
   // ------------------------------------------------------------------
   logic signed [17:0] bx_s1_ff, by_s1_ff;

   always_ff @(posedge clock) begin
      bx_s1_ff <= $signed({2'b00, req_point_x}) - $signed({{2{bottom_x_ff[15]}}, bottom_x_ff});
      by_s1_ff <= $signed({2'b00, req_point_y}) - $signed({{2{bottom_y_ff[15]}}, bottom_y_ff});
   end

   // ------------------------------------------------------------------
   // Stage 2: all pairwise products, one multiplier deep
   // ------------------------------------------------------------------
   logic signed [34:0] axbx_s2_ff, ayby_s2_ff, axby_s2_ff, aybx_s2_ff;
   logic signed [35:0] bxbx_s2_ff, byby_s2_ff;
   logic signed [33:0] axax_s2_ff, ayay_s2_ff;

   always_ff @(posedge clock) begin
      axbx_s2_ff <= ax * bx_s1_ff;
      ayby_s2_ff <= ay * by_s1_ff;
      axby_s2_ff <= ax * by_s1_ff;
      aybx_s2_ff <= ay * bx_s1_ff;
      bxbx_s2_ff <= bx_s1_ff * bx_s1_ff;
      byby_s2_ff <= by_s1_ff * by_s1_ff;
      axax_s2_ff <= ax * ax;
      ayay_s2_ff <= ay * ay;
   end

   // ------------------------------------------------------------------
   // Stage 3: dot, cross, |a|^2 and |b|^2
   // ------------------------------------------------------------------
   logic signed [35:0] dot_s3_ff, cross_s3_ff;
   logic [32:0]        l2_s3_ff;
   logic [34:0]        d2_s3_ff;

   always_ff @(posedge clock) begin
      dot_s3_ff   <= axbx_s2_ff + ayby_s2_ff;
      cross_s3_ff <= axby_s2_ff - aybx_s2_ff;
      l2_s3_ff    <= {1'b0, axax_s2_ff[31:0]} + {1'b0, ayay_s2_ff[31:0]};
      d2_s3_ff    <= {1'b0, bxbx_s2_ff[33:0]} + {1'b0, byby_s2_ff[33:0]};
   end

   // ------------------------------------------------------------------
   // Stage 4: foot products, magnitudes, square-root operand
   // ------------------------------------------------------------------
   logic signed [52:0]  axdot_s4_ff, aydot_s4_ff;
   logic [32:0]         l2_s4_ff;
   logic [63:0]         sq_rem_ff  [StPre:StSqEnd];
   logic [31:0]         sq_root_ff [StPre:StSqEnd];
   logic [34:0]         cmag_ff    [StPre:StSqEnd];
   logic [34:0]         dmag_ff    [StPre:StSqEnd];
   ptsbc_pkg::meta_type meta_ff    [StPre:StDivEnd];

   logic               l2zero_s3;
   logic signed [35:0] cross_abs_s3, dot_abs_s3;
   logic [34:0]        sq_arg_s3;

   always_comb begin
      l2zero_s3    = (l2_s3_ff == '0);
      cross_abs_s3 = cross_s3_ff[35] ? -cross_s3_ff : cross_s3_ff;
      dot_abs_s3   = dot_s3_ff[35] ? -dot_s3_ff : dot_s3_ff;
      // Zero-length axis: the root of |b|^2 feeds the across path instead
      sq_arg_s3    = l2zero_s3 ? d2_s3_ff : {2'b00, l2_s3_ff};
   end

   always_ff @(posedge clock) begin
      axdot_s4_ff        <= ax * dot_s3_ff;
      aydot_s4_ff        <= ay * dot_s3_ff;
      l2_s4_ff           <= l2_s3_ff;
      sq_rem_ff[StPre]   <= {1'b0, sq_arg_s3, 28'd0};
      sq_root_ff[StPre]  <= '0;
      cmag_ff[StPre]     <= cross_abs_s3[34:0];
      dmag_ff[StPre]     <= dot_abs_s3[34:0];
      meta_ff[StPre].neg    <= cross_s3_ff[35] & ~l2zero_s3;
      meta_ff[StPre].l2zero <= l2zero_s3;
   end

   for (genvar j = StPre + 1; j <= StDivEnd; j++) begin : g_meta
      always_ff @(posedge clock) begin
         meta_ff[j] <= meta_ff[j-1];
      end
   end

   // ------------------------------------------------------------------
   // Square root: one result bit per stage, remainder kept as v - r^2
   // ------------------------------------------------------------------
   for (genvar i = 1; i <= SqBits; i++) begin : g_sqrt
      localparam int K = SqBits - i;
      localparam int N = StPre + i;
      logic [64:0] trial;
      logic        take;

      always_comb begin
         trial = ptsbc_pkg::sqrt_trial(sq_root_ff[N-1], K);
         take  = ({1'b0, sq_rem_ff[N-1]} >= trial);
      end

      always_ff @(posedge clock) begin
         sq_rem_ff[N]  <= take ? (sq_rem_ff[N-1] - trial[63:0]) : sq_rem_ff[N-1];
         sq_root_ff[N] <= take ? (sq_root_ff[N-1] | (32'd1 << K)) : sq_root_ff[N-1];
         cmag_ff[N]    <= cmag_ff[N-1];
         dmag_ff[N]    <= dmag_ff[N-1];
      end
   end

   // ------------------------------------------------------------------
   // Foot: offset = round(a * dot / L2), restoring divide, one bit a stage
   // ------------------------------------------------------------------
   logic [51:0] fnum_x_ff [StFnum:StFdivEnd];
   logic [51:0] fnum_y_ff [StFnum:StFdivEnd];
   logic [17:0] fq_x_ff   [StFnum:StFdivEnd];
   logic [17:0] fq_y_ff   [StFnum:StFdivEnd];
   logic        fneg_x_ff [StFnum:StFdivEnd];
   logic        fneg_y_ff [StFnum:StFdivEnd];
   logic [32:0] fden_ff   [StFnum:StFdivEnd];

   logic signed [52:0] axdot_abs, aydot_abs;

   always_comb begin
      axdot_abs = axdot_s4_ff[52] ? -axdot_s4_ff : axdot_s4_ff;
      aydot_abs = aydot_s4_ff[52] ? -aydot_s4_ff : aydot_s4_ff;
   end

   // Add half the divisor to round half away from zero
   always_ff @(posedge clock) begin
      fnum_x_ff[StFnum] <= axdot_abs[51:0] + {20'd0, l2_s4_ff[32:1]};
      fnum_y_ff[StFnum] <= aydot_abs[51:0] + {20'd0, l2_s4_ff[32:1]};
      fq_x_ff[StFnum]   <= '0;
      fq_y_ff[StFnum]   <= '0;
      fneg_x_ff[StFnum] <= axdot_s4_ff[52];
      fneg_y_ff[StFnum] <= aydot_s4_ff[52];
      fden_ff[StFnum]   <= l2_s4_ff;
   end

   for (genvar i = 1; i <= FdBits; i++) begin : g_fdiv
      localparam int K = FdBits - i;
      localparam int N = StFnum + i;
      logic [52:0] den_sh;
      logic        take_x, take_y;

      always_comb begin
         den_sh = {20'd0, fden_ff[N-1]} << K;
         take_x = ({1'b0, fnum_x_ff[N-1]} >= den_sh);
         take_y = ({1'b0, fnum_y_ff[N-1]} >= den_sh);
      end

      always_ff @(posedge clock) begin
         fnum_x_ff[N] <= take_x ? (fnum_x_ff[N-1] - den_sh[51:0]) : fnum_x_ff[N-1];
         fnum_y_ff[N] <= take_y ? (fnum_y_ff[N-1] - den_sh[51:0]) : fnum_y_ff[N-1];
         fq_x_ff[N]   <= take_x ? (fq_x_ff[N-1] | (18'd1 << K)) : fq_x_ff[N-1];
         fq_y_ff[N]   <= take_y ? (fq_y_ff[N-1] | (18'd1 << K)) : fq_y_ff[N-1];
         fneg_x_ff[N] <= fneg_x_ff[N-1];
         fneg_y_ff[N] <= fneg_y_ff[N-1];
         fden_ff[N]   <= fden_ff[N-1];
      end
   end

   // Apply sign, add to bottom, clamp; then hold until the ratios catch up
   ptsbc_pkg::foot_type foot_ff [StFoot:StDivEnd];

   logic signed [19:0] offx, offy, sumx, sumy;
   logic [16:0]        clx, cly;

   always_comb begin
      offx = fneg_x_ff[StFdivEnd] ? -$signed({2'b00, fq_x_ff[StFdivEnd]})
                                  :  $signed({2'b00, fq_x_ff[StFdivEnd]});
      offy = fneg_y_ff[StFdivEnd] ? -$signed({2'b00, fq_y_ff[StFdivEnd]})
                                  :  $signed({2'b00, fq_y_ff[StFdivEnd]});
      if (meta_ff[StFdivEnd].l2zero) begin
         offx = '0;
         offy = '0;
      end
      sumx = $signed({{4{bottom_x_ff[15]}}, bottom_x_ff}) + offx;
      sumy = $signed({{4{bottom_y_ff[15]}}, bottom_y_ff}) + offy;
      clx  = ptsbc_pkg::clamp_foot(sumx);
      cly  = ptsbc_pkg::clamp_foot(sumy);
   end

   always_ff @(posedge clock) begin
      foot_ff[StFoot].fx  <= $signed(clx[15:0]);
      foot_ff[StFoot].fy  <= $signed(cly[15:0]);
      foot_ff[StFoot].sat <= clx[16] | cly[16];
   end

   for (genvar j = StFoot + 1; j <= StDivEnd; j++) begin : g_foot_dly
      always_ff @(posedge clock) begin
         foot_ff[j] <= foot_ff[j-1];
      end
   end

   // ------------------------------------------------------------------
   // Divisor build: w * S and h * S (w * 2^14 on a zero-length axis)
   // ------------------------------------------------------------------
   logic [62:0] a_num_pre_ff, l_num_pre_ff;
   logic [47:0] a_den_pre_ff, l_den_pre_ff;
   logic [31:0] a_mul;

   always_comb begin
      a_mul = meta_ff[StSqEnd].l2zero ? (32'd1 << 14) : sq_root_ff[StSqEnd];
   end

   always_ff @(posedge clock) begin
      a_den_pre_ff <= beam_width_ff * a_mul;
      l_den_pre_ff <= beam_length_ff * sq_root_ff[StSqEnd];
      a_num_pre_ff <= meta_ff[StSqEnd].l2zero ? {18'd0, sq_root_ff[StSqEnd], 13'd0}
                                              : {1'b0, cmag_ff[StSqEnd], 27'd0};
      l_num_pre_ff <= {dmag_ff[StSqEnd], 28'd0};
   end

   // ------------------------------------------------------------------
   // Overflow check, then 16-stage restoring divide for across and along
   // ------------------------------------------------------------------
   logic [62:0] a_rem_ff [StOvf:StDivEnd];
   logic [62:0] l_rem_ff [StOvf:StDivEnd];
   logic [47:0] a_den_ff [StOvf:StDivEnd];
   logic [47:0] l_den_ff [StOvf:StDivEnd];
   logic [15:0] a_q_ff   [StOvf:StDivEnd];
   logic [15:0] l_q_ff   [StOvf:StDivEnd];
   logic        a_ovf_ff [StOvf:StDivEnd];
   logic        l_ovf_ff [StOvf:StDivEnd];

   always_ff @(posedge clock) begin
      a_rem_ff[StOvf] <= a_num_pre_ff;
      l_rem_ff[StOvf] <= l_num_pre_ff;
      a_den_ff[StOvf] <= a_den_pre_ff;
      l_den_ff[StOvf] <= l_den_pre_ff;
      a_q_ff[StOvf]   <= '0;
      l_q_ff[StOvf]   <= '0;
      // Quotient of 2^16 or more saturates either way
      a_ovf_ff[StOvf] <= ({1'b0, a_num_pre_ff} >= {a_den_pre_ff, 16'd0});
      l_ovf_ff[StOvf] <= ({1'b0, l_num_pre_ff} >= {l_den_pre_ff, 16'd0});
   end

   for (genvar i = 1; i <= QdBits; i++) begin : g_qdiv
      localparam int K = QdBits - i;
      localparam int N = StOvf + i;
      logic [63:0] a_sh, l_sh;
      logic        take_a, take_l;

      always_comb begin
         a_sh   = {16'd0, a_den_ff[N-1]} << K;
         l_sh   = {16'd0, l_den_ff[N-1]} << K;
         take_a = ({1'b0, a_rem_ff[N-1]} >= a_sh);
         take_l = ({1'b0, l_rem_ff[N-1]} >= l_sh);
      end

      always_ff @(posedge clock) begin
         a_rem_ff[N] <= take_a ? (a_rem_ff[N-1] - a_sh[62:0]) : a_rem_ff[N-1];
         l_rem_ff[N] <= take_l ? (l_rem_ff[N-1] - l_sh[62:0]) : l_rem_ff[N-1];
         a_q_ff[N]   <= take_a ? (a_q_ff[N-1] | (16'd1 << K)) : a_q_ff[N-1];
         l_q_ff[N]   <= take_l ? (l_q_ff[N-1] | (16'd1 << K)) : l_q_ff[N-1];
         a_den_ff[N] <= a_den_ff[N-1];
         l_den_ff[N] <= l_den_ff[N-1];
         a_ovf_ff[N] <= a_ovf_ff[N-1];
         l_ovf_ff[N] <= l_ovf_ff[N-1];
      end
   end

   // ------------------------------------------------------------------
   // Final stage: saturate and register the result beat
   // ------------------------------------------------------------------
   logic signed [15:0] across_in;
   logic [15:0]        along_in;
   logic               sat_a, sat_l;
   logic [15:0]        aq, lq;
   logic               aovf, lovf, neg, l2zero;

   always_comb begin
      aq     = a_q_ff[StDivEnd];
      lq     = l_q_ff[StDivEnd];
      aovf   = a_ovf_ff[StDivEnd];
      lovf   = l_ovf_ff[StDivEnd];
      neg    = meta_ff[StDivEnd].neg;
      l2zero = meta_ff[StDivEnd].l2zero;

      sat_a     = 1'b0;
      across_in = $signed(aq);
      if (beam_width_ff == '0) begin
         // No width: pin to the rail on the side of the cross product
         sat_a     = 1'b1;
         across_in = neg ? ptsbc_pkg::ACROSS_MIN : ptsbc_pkg::ACROSS_MAX;
      end else if (neg) begin
         if (aovf || (aq > ptsbc_pkg::ALONG_SAT_NEG)) begin
            sat_a     = 1'b1;
            across_in = ptsbc_pkg::ACROSS_MIN;
         end else begin
            across_in = $signed(16'd0 - aq);
         end
      end else if (aovf || (aq > ptsbc_pkg::ALONG_SAT_POS)) begin
         sat_a     = 1'b1;
         across_in = ptsbc_pkg::ACROSS_MAX;
      end

      sat_l    = 1'b0;
      along_in = lq;
      if ((beam_length_ff == '0) || (!l2zero && lovf)) begin
         sat_l    = 1'b1;
         along_in = ptsbc_pkg::ALONG_MAX;
      end else if (l2zero) begin
         along_in = '0;
      end
   end

   logic signed [15:0] across_ff, foot_x_ff, foot_y_ff;
   logic [15:0]        along_ff;
   logic               sat_ff;

   always_ff @(posedge clock) begin
      across_ff <= across_in;
      along_ff  <= along_in;
      foot_x_ff <= foot_ff[StDivEnd].fx;
      foot_y_ff <= foot_ff[StDivEnd].fy;
      sat_ff    <= sat_a | sat_l | foot_ff[StDivEnd].sat;
   end

   assign rsp_valid      = vld_ff[StOut];
   assign rsp_across_pos = across_ff;
   assign rsp_along_pos  = along_ff;
   assign rsp_foot_x     = foot_x_ff;
   assign rsp_foot_y     = foot_y_ff;
   assign rsp_saturated  = sat_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   a_beat_has_source: assert property (@(posedge clock) disable iff (reset)
      vld_ff[StOut] |-> $past(vld_ff[1], StOut - 1))
      else $error("result beat without a matching start beat");

   a_sqrt_remainder: assert property (@(posedge clock) disable iff (reset)
      vld_ff[StSqEnd] |-> (sq_rem_ff[StSqEnd] <= {31'd0, sq_root_ff[StSqEnd], 1'b0}))
      else $error("square root remainder out of range");

   a_across_div_done: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[StDivEnd] && !a_ovf_ff[StDivEnd]) |->
         ({1'b0, a_rem_ff[StDivEnd]} < {16'd0, a_den_ff[StDivEnd]}))
      else $error("across divider left remainder above divisor");

   a_zero_width_sat: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (beam_width_ff == '0)) |-> rsp_saturated)
      else $error("zero beam width without saturation flag");

   a_zero_length_along: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (beam_length_ff == '0)) |->
         (rsp_along_pos == ptsbc_pkg::ALONG_MAX) && rsp_saturated)
      else $error("zero beam length not clamped");

endmodule

`default_nettype wire
